/* rtl/core/gct_pkg.sv */
// ----------------------------------------------------------------------------
// gct_pkg
// Shared widths, constants and types of the genotype count table core.
// ----------------------------------------------------------------------------
package gct_pkg;

   localparam int IDX_W   = 6;   // ploidy and allele count fields
   localparam int COUNT_W = 20;  // genotype count and limit
   localparam int CELL_W  = 21;  // table cell, two's complement, sentinel is -1
   localparam int SUM_W   = 22;  // left plus above before the check

   localparam int DEF_PLOIDY_CAP = 63;
   localparam int DEF_ALLELE_CAP = 63;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(500500);
   localparam logic [CELL_W-1:0]  SENTINEL    = {CELL_W{1'b1}};

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_COUNT_LIMIT = 1'b0;  // word index of count_limit

   typedef struct packed {
      logic [CELL_W-1:0] left;
      logic [CELL_W-1:0] above;
   } cell_operands_type;

endpackage

/* rtl/core/gct_if.sv */
// ----------------------------------------------------------------------------
// gct_req_if / gct_rsp_if
// Valid/ready channels carrying a query item and a result item.
// ----------------------------------------------------------------------------
interface gct_req_if;
   import gct_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] ploidy;
   logic [IDX_W-1:0] allele_num;

   modport source (output valid, output ploidy, output allele_num, input ready);
   modport sink   (input valid, input ploidy, input allele_num, output ready);
endinterface

interface gct_rsp_if;
   import gct_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] genotype_total;
   logic               overflow;

   modport source (output valid, output genotype_total, output overflow, input ready);
   modport sink   (input valid, input genotype_total, input overflow, output ready);
endinterface

/* rtl/core/genotype_count_table_dp_core.sv */
// ----------------------------------------------------------------------------
// genotype_count_table_dp_core
// Genotype count from a capped Pascal-style table, one cell per cycle within a row.
//
// A query item (ploidy, allele_num) arrives on req; both are clamped to
// PLOIDY_CAP and ALLELE_CAP. The core walks the table row by row in a row
// buffer RAM through one shared add-and-check unit, one cell per cycle
// within a row, and each row opens with the RAM read of its ST_ROW state.
// req.ready is high only while no query is in flight, so one item is worked
// at a time and a new query is not taken before the last one is done. The
// result item sits in an output register until rsp.ready takes it; the
// next query can be accepted and computed meanwhile, and holds at its end
// until the output register is free. A result of overflow carries total 0.
// count_limit is written through the csr port; the user must do so only
// while the core is idle, the block does not enforce it. Reset (synchronous)
// drops any query and result and sets count_limit to 500500; the row buffer
// is not cleared, every query writes before it reads.
// ----------------------------------------------------------------------------
module genotype_count_table_dp_core #(
   parameter int PLOIDY_CAP = gct_pkg::DEF_PLOIDY_CAP,
   parameter int ALLELE_CAP = gct_pkg::DEF_ALLELE_CAP
) (
   input  logic                           clock,
   input  logic                           reset,
   gct_req_if.sink                        req,
   gct_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gct_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gct_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gct_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import gct_pkg::*;

   localparam int PW    = $clog2(PLOIDY_CAP + 1);
   localparam int AW    = $clog2(ALLELE_CAP + 1);
   localparam int DEPTH = ALLELE_CAP + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROW  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [PW-1:0]      pl_ff, pl_in;
   logic [AW-1:0]      al_ff, al_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [AW-1:0]      a_ff, a_in;
   logic [CELL_W-1:0]  left_ff, left_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               ovf_ff, ovf_in;

   logic [PW-1:0]      pl_clamp;
   logic [AW-1:0]      al_clamp;
   logic               ram_we;
   logic [AW-1:0]      ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;
   logic [COUNT_W-1:0] count_limit;
   cell_operands_type  operands;
   logic [CELL_W-1:0]  step_cell;
   logic               slot_free;

   gct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .count_limit (count_limit)
   );

   gct_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_row_buffer (
      .clock (clock),
      .we    (ram_we),
      .waddr (a_ff),
      .wdata (step_cell),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // row 1 sees the all-ones row 0 as a constant, so row 0 is never stored
   assign operands.left  = left_ff;
   assign operands.above = (p_ff == PW'(1)) ? CELL_W'(1) : ram_rdata;

   gct_cell_unit u_cell (
      .operands    (operands),
      .count_limit (count_limit),
      .cell_out    (step_cell)
   );

   always_comb begin
      if (int'(req.ploidy) > PLOIDY_CAP) begin
         pl_clamp = PW'(PLOIDY_CAP);
      end else begin
         pl_clamp = PW'(req.ploidy);
      end
      if (int'(req.allele_num) > ALLELE_CAP) begin
         al_clamp = AW'(ALLELE_CAP);
      end else begin
         al_clamp = AW'(req.allele_num);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in  = state_ff;
      pl_in     = pl_ff;
      al_in     = al_ff;
      p_in      = p_ff;
      a_in      = a_ff;
      left_in   = left_ff;
      cell_in   = cell_ff;
      ram_we    = 1'b0;
      ram_raddr = a_ff + AW'(1);
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               pl_in = pl_clamp;
               al_in = al_clamp;
               p_in  = '0;
               if (pl_clamp == '0 || al_clamp == '0) begin
                  // column 0 holds 0, row 0 holds 1
                  cell_in  = (al_clamp == '0) ? '0 : CELL_W'(1);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            p_in      = p_ff + PW'(1);
            a_in      = AW'(1);
            left_in   = '0;
            ram_raddr = AW'(1);
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            ram_we  = 1'b1;
            left_in = step_cell;
            if (a_ff == al_ff) begin
               if (p_ff == pl_ff) begin
                  cell_in  = step_cell;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROW;
               end
            end else begin
               a_in = a_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         ovf_in       = (cell_ff == SENTINEL);
         total_in     = (cell_ff == SENTINEL) ? '0 : cell_ff[COUNT_W-1:0];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pl_ff    <= pl_in;
      al_ff    <= al_in;
      p_ff     <= p_in;
      a_ff     <= a_in;
      left_ff  <= left_in;
      cell_ff  <= cell_in;
      total_ff <= total_in;
      ovf_ff   <= ovf_in;
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.genotype_total = total_ff;
   assign rsp.overflow       = ovf_ff;

   // cell walk stays inside the query's part of the table
   a_run_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> a_ff != '0 && a_ff <= al_ff && p_ff != '0 && p_ff <= pl_ff)
      else $error("cell index outside the query window");

   // the read that opens a row is always followed by the row walk
   a_row_then_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW |=> state_ff == ST_RUN)
      else $error("row start not followed by cell steps");

   // a new result is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(total_ff) && $stable(ovf_ff))
      else $error("pending result overwritten");

   // overflow results carry a zero count
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ovf_ff |-> total_ff == '0)
      else $error("overflow result with nonzero count");

endmodule

/* rtl/core/gct_ram.sv */
// ----------------------------------------------------------------------------
// gct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/gct_cell_unit.sv */
// ----------------------------------------------------------------------------
// gct_cell_unit
// One recurrence step: left plus above, checked against the count limit.
// ----------------------------------------------------------------------------
module gct_cell_unit (
   input  gct_pkg::cell_operands_type      operands,
   input  logic [gct_pkg::COUNT_W-1:0]     count_limit,
   output logic [gct_pkg::CELL_W-1:0]      cell_out
);
   import gct_pkg::*;

   logic signed [SUM_W-1:0] left_ext;
   logic signed [SUM_W-1:0] above_ext;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] limit_ext;

   always_comb begin
      left_ext  = SUM_W'($signed(operands.left));
      above_ext = SUM_W'($signed(operands.above));
      limit_ext = $signed({{(SUM_W-COUNT_W){1'b0}}, count_limit});
      sum       = left_ext + above_ext;
      // a sentinel above drives the sum under the left cell
      if (sum > limit_ext || sum < left_ext) begin
         cell_out = SENTINEL;
      end else begin
         cell_out = sum[CELL_W-1:0];
      end
   end

endmodule

/* rtl/core/gct_csr.sv */
// ----------------------------------------------------------------------------
// gct_csr
// APB-style register port holding count_limit.
// ----------------------------------------------------------------------------
module gct_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gct_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gct_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gct_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [gct_pkg::COUNT_W-1:0]    count_limit
);
   import gct_pkg::*;

   logic [COUNT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] limit_in;
   logic               hit;

   assign hit = (csr_paddr[2] == REG_COUNT_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         limit_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = hit ? {{(CSR_DATA_W-COUNT_W){1'b0}}, limit_ff} : '0;
   assign count_limit = limit_ff;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for genotype_count_table_dp_core. Queries come from a
// directed list and then random phases, each under its own count_limit and
// idle mix. Every accepted query is run through a local row-buffer model of
// the capped Pascal table. Each result item is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
   import gct_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int LATENCY_TAIL = 4100;
   localparam int HOLD_CYCLES  = 2500;
   localparam int SETTLE       = 16;

   localparam logic [CSR_ADDR_W-1:0] ADDR_COUNT_LIMIT = CSR_ADDR_W'(4 * REG_COUNT_LIMIT);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED    = CSR_ADDR_W'(4 * (REG_COUNT_LIMIT + 1));

   localparam int N_DIRECTED = 20;
   localparam int DIRECTED_QUERIES [N_DIRECTED][2] = '{
      '{0, 0}, '{0, 1}, '{0, 63}, '{63, 0}, '{1, 0}, '{1, 1}, '{1, 63}, '{63, 1},
      '{2, 2}, '{2, 63}, '{5, 7}, '{12, 12}, '{63, 63}, '{30, 30}, '{63, 62},
      '{62, 63}, '{20, 45}, '{42, 21}, '{3, 3}, '{21, 42}
   };

   typedef struct packed {
      logic [IDX_W-1:0] ploidy;
      logic [IDX_W-1:0] allele_num;
   } query_type;

   typedef struct packed {
      logic [COUNT_W-1:0] genotype_total;
      logic               overflow;
   } genotype_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gct_req_if req_if ();
   gct_rsp_if rsp_if ();

   genotype_count_table_dp_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // model state
   logic [COUNT_W-1:0]       count_limit_shadow = LIMIT_RESET;
   logic signed [CELL_W-1:0] row_cells [0:DEF_ALLELE_CAP];

   query_type           pending_queries [$];
   genotype_result_type expected_genotypes [$];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   logic rsp_hold      = 1'b0;
   int  error_count    = 0;
   int  results_checked  = 0;
   int  overflow_results = 0;
   int  limit_writes     = 0;
   int  cycle_count      = 0;

   // walk the table row by row through one row buffer, as the block does
   function automatic genotype_result_type predict_genotypes(input logic [IDX_W-1:0] ploidy,
                                                             input logic [IDX_W-1:0] alleles);
      int                       rows;
      int                       cols;
      logic signed [SUM_W-1:0]  left;
      logic signed [SUM_W-1:0]  above;
      logic signed [SUM_W-1:0]  sum;
      logic signed [SUM_W-1:0]  cap;
      genotype_result_type      res;
      rows = (int'(ploidy) > DEF_PLOIDY_CAP) ? DEF_PLOIDY_CAP : int'(ploidy);
      cols = (int'(alleles) > DEF_ALLELE_CAP) ? DEF_ALLELE_CAP : int'(alleles);
      cap  = $signed({2'b00, count_limit_shadow});
      row_cells[0] = '0;
      for (int a = 1; a <= cols; a++) row_cells[a] = CELL_W'(1);
      for (int p = 1; p <= rows; p++) begin
         row_cells[0] = '0;
         for (int a = 1; a <= cols; a++) begin
            left  = row_cells[a-1];
            above = row_cells[a];
            sum   = left + above;
            // a sentinel above makes the sum drop below the left cell
            if (sum > cap || sum < left) row_cells[a] = SENTINEL;
            else row_cells[a] = sum[CELL_W-1:0];
         end
      end
      if (row_cells[cols] == SENTINEL) begin
         res.genotype_total = '0;
         res.overflow       = 1'b1;
      end else begin
         res.genotype_total = row_cells[cols][COUNT_W-1:0];
         res.overflow       = 1'b0;
      end
      return res;
   endfunction

   function automatic query_type random_query(input int span);
      query_type q;
      // mostly short walks, a quarter across the full range
      if ($urandom_range(3) == 0) begin
         q.ploidy     = IDX_W'($urandom);
         q.allele_num = IDX_W'($urandom);
      end else begin
         q.ploidy     = IDX_W'($urandom_range(span));
         q.allele_num = IDX_W'($urandom_range(span));
      end
      return q;
   endfunction

   // query driver
   always @(posedge clock) begin
      query_type next_query;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_genotypes.push_back(predict_genotypes(req_if.ploidy,
                                                           req_if.allele_num));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_query = pending_queries.pop_front();
               req_if.valid      <= 1'b1;
               req_if.ploidy     <= next_query.ploidy;
               req_if.allele_num <= next_query.allele_num;
            end else begin
               req_if.valid      <= 1'b0;
               req_if.ploidy     <= IDX_W'($urandom);
               req_if.allele_num <= IDX_W'($urandom);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      genotype_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_genotypes.size() == 0) begin
               $error("unexpected result item: genotype_total %0d overflow %0b",
                      rsp_if.genotype_total, rsp_if.overflow);
               error_count++;
            end else begin
               want = expected_genotypes.pop_front();
               if (rsp_if.genotype_total !== want.genotype_total) begin
                  $error("genotype_total mismatch: expected %0d, got %0d",
                         want.genotype_total, rsp_if.genotype_total);
                  error_count++;
               end
               if (rsp_if.overflow !== want.overflow) begin
                  $error("overflow mismatch: expected %0b, got %0b",
                         want.overflow, rsp_if.overflow);
                  error_count++;
               end
               results_checked++;
               if (want.overflow) overflow_results++;
            end
         end
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("genotype_count_table_dp_core test failed");
         $finish;
      end
   end

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_count_limit();
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, ADDR_COUNT_LIMIT, '0, got);
      if (got !== CSR_DATA_W'(count_limit_shadow)) begin
         $error("count_limit mismatch: expected %0d, got %0d", count_limit_shadow, got);
         error_count++;
      end
   endtask

   task automatic set_count_limit(input logic [COUNT_W-1:0] limit);
      logic [CSR_DATA_W-1:0] unused;
      // junk in the upper bits must be dropped
      csr_access(1'b1, ADDR_COUNT_LIMIT,
                 {(CSR_DATA_W-COUNT_W)'($urandom), limit}, unused);
      count_limit_shadow = limit;
      limit_writes++;
      check_count_limit();
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_queries.size() != 0 || req_if.valid || expected_genotypes.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] limit, input int send_pct,
                            input int recv_pct, input int n_items, input int span,
                            input bit hold_off);
      set_count_limit(limit);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (hold_off) begin
         fork
            begin
               @(posedge clock);
               rsp_hold <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_hold <= 1'b0;
            end
         join_none
      end
      repeat (n_items) pending_queries.push_back(random_query(span));
      wait_drained();
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] unused;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset value, then the corners under it
      check_count_limit();
      foreach (DIRECTED_QUERIES[i]) begin
         pending_queries.push_back('{ploidy: IDX_W'(DIRECTED_QUERIES[i][0]),
                                     allele_num: IDX_W'(DIRECTED_QUERIES[i][1])});
      end
      wait_drained();

      run_phase('0, 0, 0, 15, 12, 1'b0);                    // row 0 survives a zero limit
      run_phase({COUNT_W{1'b1}}, 51, 0, 30, 16, 1'b0);
      run_phase(COUNT_W'($urandom_range(5000, 1)), 0, 51, 25, 16, 1'b0);

      // a write past the last register leaves count_limit alone
      csr_access(1'b1, ADDR_UNMAPPED, CSR_DATA_W'($urandom), unused);
      check_count_limit();

      run_phase(LIMIT_RESET, 34, 34, 30, 16, 1'b0);
      run_phase(COUNT_W'($urandom_range(200000, 20)), 0, 0, 20, 8, 1'b1);

      repeat (LATENCY_TAIL) @(posedge clock);
      $display("checked %0d result items under %0d count_limit settings, %0d overflowed",
               results_checked, limit_writes, overflow_results);
      $display("idle mixes: none, sender, receiver, both, and a long receiver hold-off");
      if (error_count == 0 && expected_genotypes.size() == 0) begin
         $display("genotype_count_table_dp_core test passed");
      end else begin
         $display("genotype_count_table_dp_core test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/gct_pkg.sv
rtl/core/gct_if.sv
rtl/core/gct_ram.sv
rtl/core/gct_cell_unit.sv
rtl/core/gct_csr.sv
rtl/core/genotype_count_table_dp_core.sv
sim/testbench.sv
